>>> rtl/tcpjq_pkg.sv
// Shared types and constants for the three-class priority job queue.
package tcpjq_pkg;

    localparam int JOB_W       = 7;
    localparam int CLASS_W     = 2;
    localparam int CLASS_COUNT = 3;

    typedef logic [JOB_W-1:0]   job_t;
    typedef logic [CLASS_W-1:0] class_t;

    localparam class_t CLASS_SERVER = 2'd0;
    localparam class_t CLASS_POWER  = 2'd1;
    localparam class_t CLASS_USER   = 2'd2;
    localparam class_t CLASS_NONE   = 2'd3;

    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_SELECT  = 1'b1
    } action_t;

    typedef struct packed {
        logic   found;
        class_t served_class;
        logic   dropped;
    } res_meta_t;

endpackage

>>> rtl/three_class_priority_job_queue_top.sv
// A taken request passes the request register and the queue update before the result register raises its strobe.
// Throughput: one request per cycle; busy stays low, and the strobe cannot be held off.
// Stages: request register, queue update with head read, result register.
// Reset clears pointers, fill counts and the pipeline valids; queue storage is not cleared.
// Each class is a FIFO of QUEUE_DEPTH entries held in its own single-port-read memory.
module three_class_priority_job_queue_top
    import tcpjq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic [CLASS_W-1:0] queue_class,
    input  logic [JOB_W-1:0]   job_number,
    output logic               done,
    output logic [JOB_W-1:0]   job_out,
    output logic               job_found,
    output logic [CLASS_W-1:0] served_class,
    output logic               dropped_full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic       req_valid_reg;
    action_t    req_action_reg;
    class_t     req_class_reg;
    job_t       req_job_reg;

    logic [PTR_W-1:0] head_reg [CLASS_COUNT];
    logic [PTR_W-1:0] head_next [CLASS_COUNT];
    logic [PTR_W-1:0] tail_reg [CLASS_COUNT];
    logic [PTR_W-1:0] tail_next [CLASS_COUNT];
    logic [CNT_W-1:0] cnt_reg [CLASS_COUNT];
    logic [CNT_W-1:0] cnt_next [CLASS_COUNT];

    logic [CLASS_COUNT-1:0] full;
    logic [CLASS_COUNT-1:0] not_empty;
    logic [CLASS_COUNT-1:0] enq_ok;
    logic [CLASS_COUNT-1:0] pop;

    job_t       rd_data_reg [CLASS_COUNT];
    logic       meta_valid_reg;
    res_meta_t  meta_reg;
    res_meta_t  meta_next;

    logic       done_reg;
    job_t       job_out_reg;
    job_t       job_out_next;
    res_meta_t  out_meta_reg;

    assign busy = 1'b0;

    // Capture the request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_action_reg <= action_t'(action);
            req_class_reg  <= queue_class;
            req_job_reg    <= job_number;
        end
    end

    // Decide push or pop and the priority pick.
    always_comb
    begin
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            full[c]      = (cnt_reg[c] == CNT_W'(QUEUE_DEPTH));
            not_empty[c] = (cnt_reg[c] != '0);
        end

        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            enq_ok[c] = req_valid_reg && (req_action_reg == ACT_ENQUEUE)
                        && (req_class_reg == CLASS_W'(c)) && !full[c];
        end

        pop[0] = req_valid_reg && (req_action_reg == ACT_SELECT) && not_empty[0];
        pop[1] = req_valid_reg && (req_action_reg == ACT_SELECT)
                 && !not_empty[0] && not_empty[1];
        pop[2] = req_valid_reg && (req_action_reg == ACT_SELECT)
                 && !not_empty[0] && !not_empty[1] && not_empty[2];

        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            head_next[c] = head_reg[c];
            tail_next[c] = tail_reg[c];
            cnt_next[c]  = cnt_reg[c];
            if (enq_ok[c])
            begin
                tail_next[c] = (tail_reg[c] == PTR_W'(QUEUE_DEPTH - 1))
                               ? '0 : tail_reg[c] + PTR_W'(1);
                cnt_next[c]  = cnt_reg[c] + CNT_W'(1);
            end
            if (pop[c])
            begin
                head_next[c] = (head_reg[c] == PTR_W'(QUEUE_DEPTH - 1))
                               ? '0 : head_reg[c] + PTR_W'(1);
                cnt_next[c]  = cnt_reg[c] - CNT_W'(1);
            end
        end

        meta_next.found        = |pop;
        meta_next.served_class = pop[1] ? CLASS_POWER :
                                 pop[2] ? CLASS_USER  : CLASS_SERVER;
        meta_next.dropped      = 1'b0;
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            if (req_valid_reg && (req_action_reg == ACT_ENQUEUE)
                && (req_class_reg == CLASS_W'(c)) && full[c])
            begin
                meta_next.dropped = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
            meta_valid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                head_reg[c] <= head_next[c];
                tail_reg[c] <= tail_next[c];
                cnt_reg[c]  <= cnt_next[c];
            end
            meta_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg <= meta_next;
    end

    // Per-class queue storage: write at tail, read at head.
    for (genvar c = 0; c < CLASS_COUNT; c++)
    begin : g_class
        job_t fifo_mem [QUEUE_DEPTH];

        always_ff @(posedge clk)
        begin
            if (enq_ok[c])
            begin
                fifo_mem[tail_reg[c]] <= req_job_reg;
            end
            rd_data_reg[c] <= fifo_mem[head_reg[c]];
        end
    end

    // Form the result.
    always_comb
    begin
        job_out_next = '0;
        if (meta_reg.found)
        begin
            case (meta_reg.served_class)
                CLASS_SERVER: job_out_next = rd_data_reg[0];
                CLASS_POWER:  job_out_next = rd_data_reg[1];
                CLASS_USER:   job_out_next = rd_data_reg[2];
                default:      job_out_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= meta_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        job_out_reg  <= job_out_next;
        out_meta_reg <= meta_reg;
    end

    assign done         = done_reg;
    assign job_out      = job_out_reg;
    assign job_found    = out_meta_reg.found;
    assign served_class = out_meta_reg.served_class;
    assign dropped_full = out_meta_reg.dropped;

endmodule

>>> rtl/tcpjq_checker.sv
// Port-level checker for the three-class priority job queue, with its bind.
module tcpjq_checker
    import tcpjq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [JOB_W-1:0]   job_out,
    input logic               job_found,
    input logic [CLASS_W-1:0] served_class,
    input logic               dropped_full
);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("request did not produce a result after three cycles");

    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result strobe without a matching request");

    a_found_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(job_found && dropped_full))
        else $error("result both served a job and dropped one");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !job_found) |-> (job_out == '0) && (served_class == CLASS_SERVER))
        else $error("result without a job carries a job or class");

    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (served_class != CLASS_NONE))
        else $error("served class out of range");

endmodule

bind three_class_priority_job_queue_top tcpjq_checker u_tcpjq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .job_out      (job_out),
    .job_found    (job_found),
    .served_class (served_class),
    .dropped_full (dropped_full)
);
